### rtl/core/dtdn_pkg.sv
// shared constants, types and calendar tables for the date text to day number core
package dtdn_pkg;

  // largest year that still gives a valid date
  localparam int MAX_YEAR = 65535;

  // year accumulator saturates at MAX_YEAR + 1, so it needs one value more
  localparam int YEAR_W  = $clog2(MAX_YEAR + 2);
  localparam int FIELD_W = 8;
  localparam int CHAR_W  = 8;
  localparam int DAY_W   = 25;
  localparam int SUM_W   = YEAR_W + 10;

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_DAY_DELIM = '0;
  localparam logic [CHAR_W-1:0]  DELIM_RESET   = 8'd124;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // which field of the line is being parsed
  typedef enum logic [2:0] {
    FLD_YEAR  = 3'b001,
    FLD_MONTH = 3'b010,
    FLD_DAY   = 3'b100
  } field_t;

  // where inside a field the parser stands
  typedef enum logic [3:0] {
    PH_LEAD   = 4'b0001,
    PH_PLUS   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_TRAIL  = 4'b1000
  } phase_t;

  // days in a month of a common year, zero for a month that does not exist
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days of the months before month m in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] cnt;
    case (m)
      4'd1:    cnt = 9'd0;
      4'd2:    cnt = 9'd31;
      4'd3:    cnt = 9'd59;
      4'd4:    cnt = 9'd90;
      4'd5:    cnt = 9'd120;
      4'd6:    cnt = 9'd151;
      4'd7:    cnt = 9'd181;
      4'd8:    cnt = 9'd212;
      4'd9:    cnt = 9'd243;
      4'd10:   cnt = 9'd273;
      4'd11:   cnt = 9'd304;
      4'd12:   cnt = 9'd334;
      default: cnt = 9'd0;
    endcase
    return cnt;
  endfunction

endpackage

### rtl/core/dtdn_ifs.sv
// valid/ready stream interfaces for character beats and day number beats
interface dtdn_char_if;
  import dtdn_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface dtdn_day_if;
  import dtdn_pkg::*;

  logic             valid;
  logic             ready;
  logic             date_valid;
  logic [DAY_W-1:0] day_number;

  modport source (output valid, output date_valid, output day_number, input ready);
  modport sink   (input valid, input date_valid, input day_number, output ready);
endinterface

### rtl/core/date_text_to_day_number_core.sv
// date text to day number core: character parser, date check and day count
//
// Usage: one character of a text line enters per beat on char_in, with
// line_end marking the last character. The line is read as year-month-day,
// each field with optional leading spaces, '+', digits and trailing spaces.
// The day field ends at the day delimiter register (APB offset 0) or at
// the line end; the rest of the line is ignored.
// Exactly one beat leaves on day_out per line, carrying date_valid and the
// day count with 0001-01-01 as day 1 (Julian leap rule), or 0 if invalid.
// Throughput: one character per clock, back to back, while char_in.ready
// stays high. The finished fields of a line are latched in the field
// register; the range checks and the 365 * year multiply-add then run into
// the output register.
// Stalls: while day_out is held, one more finished line waits in the field
// register; from then on char_in.ready stays low until the output frees.
// Reset (rst, synchronous) clears the parser and both result stages and
// sets the delimiter to '|'.
module date_text_to_day_number_core (
  input  logic                         clk,
  input  logic                         rst,
  dtdn_char_if.sink                    char_in,
  dtdn_day_if.source                   day_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtdn_pkg::PADDR_W-1:0] paddr,
  input  logic [dtdn_pkg::PDATA_W-1:0] pwdata,
  output logic [dtdn_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import dtdn_pkg::*;

  localparam logic [YEAR_W+3:0] YEAR_LIMIT = (YEAR_W+4)'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] YEAR_SAT   = YEAR_W'(MAX_YEAR + 1);
  localparam logic [YEAR_W-1:0] YEAR_TOP   = YEAR_W'(MAX_YEAR);

  // config register
  logic [CHAR_W-1:0] day_delim;

  // parser state
  field_t             field_index, field_index_next;
  phase_t             field_phase, field_phase_next;
  logic               digit_seen, digit_seen_next;
  logic [YEAR_W-1:0]  year_accum, year_accum_next;
  logic [FIELD_W-1:0] month_accum, month_accum_next;
  logic [FIELD_W-1:0] day_accum, day_accum_next;
  logic               error_flag, error_flag_next;
  logic               past_delim, past_delim_next;

  // field stage
  logic               a_vld;
  logic               a_base_ok;
  logic [YEAR_W-1:0]  a_year;
  logic [FIELD_W-1:0] a_month;
  logic [FIELD_W-1:0] a_day;

  // output stage
  logic               o_vld;
  logic               o_date_valid;
  logic [DAY_W-1:0]   o_day_number;

  logic o_free, a_adv, acc;

  // handshake
  assign o_free        = !o_vld || day_out.ready;
  assign a_adv         = a_vld && o_free;
  assign char_in.ready = !a_vld || o_free;
  assign acc           = char_in.valid && char_in.ready;

  // apb port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_DAY_DELIM) ?
                  PDATA_W'(day_delim) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_delim <= DELIM_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_DAY_DELIM) begin
      day_delim <= pwdata[CHAR_W-1:0];
    end
  end

  // digit accumulation, saturating
  logic [3:0]          digit;
  logic [YEAR_W+3:0]   year_mul;
  logic [FIELD_W+3:0]  month_mul, day_mul;
  logic [YEAR_W-1:0]   year_add;
  logic [FIELD_W-1:0]  month_add, day_add;
  logic                is_digit;

  assign digit    = char_in.char_code[3:0];
  assign is_digit = char_in.char_code inside {[CH_ZERO:CH_NINE]};

  always_comb begin
    year_mul  = {1'b0, year_accum, 3'b000} + {3'b000, year_accum, 1'b0} +
                (YEAR_W+4)'(digit);
    month_mul = {1'b0, month_accum, 3'b000} + {3'b000, month_accum, 1'b0} +
                (FIELD_W+4)'(digit);
    day_mul   = {1'b0, day_accum, 3'b000} + {3'b000, day_accum, 1'b0} +
                (FIELD_W+4)'(digit);
    year_add  = (year_mul > YEAR_LIMIT) ? YEAR_SAT : year_mul[YEAR_W-1:0];
    month_add = (month_mul > (FIELD_W+4)'(255)) ? 8'hFF : month_mul[FIELD_W-1:0];
    day_add   = (day_mul > (FIELD_W+4)'(255)) ? 8'hFF : day_mul[FIELD_W-1:0];
  end

  // character parser
  always_comb begin
    field_index_next = field_index;
    field_phase_next = field_phase;
    digit_seen_next  = digit_seen;
    year_accum_next  = year_accum;
    month_accum_next = month_accum;
    day_accum_next   = day_accum;
    error_flag_next  = error_flag;
    past_delim_next  = past_delim;
    if (!error_flag && !past_delim) begin
      if (field_index == FLD_DAY && char_in.char_code == day_delim) begin
        if (!digit_seen) error_flag_next = 1'b1;
        past_delim_next = 1'b1;
      end else if (char_in.char_code == CH_MINUS && field_index != FLD_DAY) begin
        if (!digit_seen) begin
          error_flag_next = 1'b1;
        end else begin
          field_index_next = (field_index == FLD_YEAR) ? FLD_MONTH : FLD_DAY;
          field_phase_next = PH_LEAD;
          digit_seen_next  = 1'b0;
        end
      end else if (char_in.char_code == CH_SPACE) begin
        case (field_phase)
          PH_PLUS:   error_flag_next  = 1'b1;
          PH_DIGITS: field_phase_next = PH_TRAIL;
          default:   ;
        endcase
      end else if (char_in.char_code == CH_PLUS) begin
        if (field_phase == PH_LEAD) field_phase_next = PH_PLUS;
        else error_flag_next = 1'b1;
      end else if (is_digit) begin
        if (field_phase == PH_TRAIL) begin
          error_flag_next = 1'b1;
        end else begin
          field_phase_next = PH_DIGITS;
          digit_seen_next  = 1'b1;
          case (field_index)
            FLD_YEAR:  year_accum_next  = year_add;
            FLD_MONTH: month_accum_next = month_add;
            default:   day_accum_next   = day_add;
          endcase
        end
      end else begin
        error_flag_next = 1'b1;
      end
    end
  end

  // parser registers, cleared after each line
  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= FLD_YEAR;
      field_phase <= PH_LEAD;
      digit_seen  <= 1'b0;
      year_accum  <= '0;
      month_accum <= '0;
      day_accum   <= '0;
      error_flag  <= 1'b0;
      past_delim  <= 1'b0;
    end else if (acc) begin
      if (char_in.line_end) begin
        field_index <= FLD_YEAR;
        field_phase <= PH_LEAD;
        digit_seen  <= 1'b0;
        year_accum  <= '0;
        month_accum <= '0;
        day_accum   <= '0;
        error_flag  <= 1'b0;
        past_delim  <= 1'b0;
      end else begin
        field_index <= field_index_next;
        field_phase <= field_phase_next;
        digit_seen  <= digit_seen_next;
        year_accum  <= year_accum_next;
        month_accum <= month_accum_next;
        day_accum   <= day_accum_next;
        error_flag  <= error_flag_next;
        past_delim  <= past_delim_next;
      end
    end
  end

  // field stage: latch the finished fields of a line
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (acc && char_in.line_end) begin
      a_vld <= 1'b1;
    end else if (a_adv) begin
      a_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && char_in.line_end) begin
      a_base_ok <= !error_flag_next && field_index_next == FLD_DAY && digit_seen_next;
      a_year    <= year_accum_next;
      a_month   <= month_accum_next;
      a_day     <= day_accum_next;
    end
  end

  // date checks and day count
  logic              leap, y_ok, m_ok, d_ok, date_ok;
  logic [3:0]        m_idx;
  logic [4:0]        dim;
  logic [YEAR_W-1:0] yy;
  logic [SUM_W-1:0]  day_sum;

  always_comb begin
    m_idx   = a_month[3:0];
    leap    = (a_year[1:0] == 2'b00);
    y_ok    = (a_year != '0) && (a_year <= YEAR_TOP);
    m_ok    = (a_month >= 8'd1) && (a_month <= 8'd12);
    dim     = month_len(m_idx) + 5'((leap && a_month == 8'd2) ? 1 : 0);
    d_ok    = (a_day != '0) && (a_day <= FIELD_W'(dim));
    date_ok = a_base_ok && y_ok && m_ok && d_ok;
    yy      = a_year - YEAR_W'(1);
    day_sum = SUM_W'(yy) * SUM_W'(365) + SUM_W'(yy >> 2) +
              SUM_W'(days_before(m_idx)) +
              SUM_W'((leap && a_month > 8'd2) ? 1 : 0) + SUM_W'(a_day);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (a_adv) begin
      o_vld <= 1'b1;
    end else if (day_out.ready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      o_date_valid <= date_ok;
      o_day_number <= date_ok ? day_sum[DAY_W-1:0] : '0;
    end
  end

  assign day_out.valid      = o_vld;
  assign day_out.date_valid = o_date_valid;
  assign day_out.day_number = o_day_number;

  // checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    o_vld && !o_date_valid |-> o_day_number == '0)
    else $error("invalid date carries a nonzero day count");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    o_vld && o_date_valid |-> o_day_number != '0)
    else $error("valid date carries a zero day count");

  a_line_latched: assert property (@(posedge clk) disable iff (rst)
    acc && char_in.line_end |=> a_vld)
    else $error("line end beat did not reach the field stage");

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    acc && char_in.line_end |=>
      field_index == FLD_YEAR && field_phase == PH_LEAD && !digit_seen &&
      !error_flag && !past_delim)
    else $error("parser not cleared after line end");

endmodule

### tb/sv/date_text_to_day_number_core_tb.sv
// testbench for date_text_to_day_number_core: directed and random lines checked against a parser model or typed results
`timescale 1ns / 100ps

module date_text_to_day_number_core_tb;
  import dtdn_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 500;
  localparam int PHASE_CHARS    = 130;
  localparam int NUM_PHASES     = 9;

  typedef struct {
    logic             date_valid;
    logic [DAY_W-1:0] day_number;
  } day_beat_t;

  typedef struct {
    logic [CHAR_W-1:0] delim;
    string             text;
    bit                typed;
    day_beat_t         result;
  } date_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dtdn_char_if char_if();
  dtdn_day_if  day_if();

  date_text_to_day_number_core uut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_if),
    .day_out (day_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // parser model state
  logic [CHAR_W-1:0] model_delim;
  field_t            model_field;
  phase_t            model_phase;
  bit                model_digit_seen;
  logic [YEAR_W-1:0] model_year;
  logic [7:0]        model_month;
  logic [7:0]        model_day;
  bit                model_error;
  bit                model_past_delim;

  day_beat_t         pending_days [$];
  bit                typed_pending;
  day_beat_t         typed_result;
  int                err_count;
  int unsigned       src_idle_pct;
  int unsigned       snk_idle_pct;
  bit                hold_req;
  logic [CHAR_W-1:0] line_buf [$];

  // directed lines; typed results only where they are obvious
  date_row_t date_rows [25] = '{
    '{8'd124, "1-1-1",            1'b1, '{1'b1, 25'd1}},
    '{8'd124, "65535-12-31",      1'b1, '{1'b1, 25'd23936658}},
    '{8'd124, "65536-1-1",        1'b1, '{1'b0, 25'd0}},
    '{8'd124, "0-1-1",            1'b1, '{1'b0, 25'd0}},
    '{8'd124, " +0004-02-29 ",    1'b0, '{1'b0, 25'd0}},
    '{8'd124, "+03 - 2 -29|",     1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1-13-1",           1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1-1-32",           1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1-1",              1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1--1",             1'b1, '{1'b0, 25'd0}},
    '{8'd124, "+-1-1",            1'b1, '{1'b0, 25'd0}},
    '{8'd124, "+ 1-1-1",          1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1+-1-1",           1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1 2-1-1",          1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1.0-1-1",          1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1-1-1-",           1'b1, '{1'b0, 25'd0}},
    '{8'd124, "99999999-300-999", 1'b1, '{1'b0, 25'd0}},
    '{8'd124, "1-1-1|-.x",        1'b1, '{1'b1, 25'd1}},
    '{8'd124, "1-1-|1",           1'b1, '{1'b0, 25'd0}},
    '{8'd124, "2000-12-31",       1'b0, '{1'b0, 25'd0}},
    '{8'd124, "7",                1'b1, '{1'b0, 25'd0}},
    '{",",    "1-01-000031,9",    1'b0, '{1'b0, 25'd0}},
    '{"7",    "2000-7-17",        1'b0, '{1'b0, 25'd0}},
    '{" ",    "12-3- 4",          1'b1, '{1'b0, 25'd0}},
    '{"-",    "1-2-3-4",          1'b0, '{1'b0, 25'd0}}
  };

  logic [CHAR_W-1:0] phase_delims [NUM_PHASES] = '{
    8'd124, ",", 8'd0, 8'd255, "5", " ", "+", "-", 8'd124
  };

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void clear_date_line();
    model_field      = FLD_YEAR;
    model_phase      = PH_LEAD;
    model_digit_seen = 1'b0;
    model_year       = '0;
    model_month      = '0;
    model_day        = '0;
    model_error      = 1'b0;
    model_past_delim = 1'b0;
  endfunction

  // one character through the field parser
  function automatic void parse_date_char(input logic [CHAR_W-1:0] c);
    int unsigned d;
    int unsigned v;
    if (model_error || model_past_delim) return;
    if (model_field == FLD_DAY && c == model_delim) begin
      if (!model_digit_seen) model_error = 1'b1;
      model_past_delim = 1'b1;
    end else if (c == CH_MINUS && model_field != FLD_DAY) begin
      if (!model_digit_seen) begin
        model_error = 1'b1;
      end else begin
        if (model_field == FLD_YEAR) model_field = FLD_MONTH;
        else model_field = FLD_DAY;
        model_phase      = PH_LEAD;
        model_digit_seen = 1'b0;
      end
    end else if (c == CH_SPACE) begin
      if (model_phase == PH_PLUS) model_error = 1'b1;
      else if (model_phase == PH_DIGITS) model_phase = PH_TRAIL;
    end else if (c == CH_PLUS) begin
      if (model_phase == PH_LEAD) model_phase = PH_PLUS;
      else model_error = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (model_phase == PH_TRAIL) begin
        model_error = 1'b1;
      end else begin
        model_phase      = PH_DIGITS;
        model_digit_seen = 1'b1;
        d = int'(c - CH_ZERO);
        // saturating decimal accumulate
        case (model_field)
          FLD_YEAR: begin
            v = 32'(model_year) * 10 + d;
            model_year = (v > MAX_YEAR) ? YEAR_W'(MAX_YEAR + 1) : YEAR_W'(v);
          end
          FLD_MONTH: begin
            v = 32'(model_month) * 10 + d;
            model_month = (v > 255) ? 8'd255 : 8'(v);
          end
          default: begin
            v = 32'(model_day) * 10 + d;
            model_day = (v > 255) ? 8'd255 : 8'(v);
          end
        endcase
      end
    end else begin
      model_error = 1'b1;
    end
  endfunction

  // range checks and day count at line end
  function automatic day_beat_t close_date_line();
    day_beat_t   r;
    bit          ok;
    bit          leap;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned dim;
    int unsigned cum;
    longint unsigned num;
    ok  = !model_error && model_field == FLD_DAY && model_digit_seen;
    y   = model_year;
    m   = model_month;
    d   = model_day;
    num = 0;
    if (ok && (y < 1 || y > MAX_YEAR)) ok = 1'b0;
    if (ok && (m < 1 || m > 12)) ok = 1'b0;
    if (ok) begin
      leap = (y % 4) == 0;
      dim  = month_days[m-1] + ((leap && m == 2) ? 1 : 0);
      if (d < 1 || d > dim) begin
        ok = 1'b0;
      end else begin
        cum = 0;
        for (int i = 0; i < m - 1; i++) cum += month_days[i];
        num = 365 * longint'(y - 1) + (y - 1) / 4 + cum + ((leap && m > 2) ? 1 : 0) + d;
      end
    end
    r.date_valid = ok;
    r.day_number = ok ? num[DAY_W-1:0] : '0;
    clear_date_line();
    return r;
  endfunction

  // accepted beats: predict on chars, compare on results
  always @(posedge clk) begin
    day_beat_t calc;
    day_beat_t want;
    if (!rst) begin
      if (char_if.valid && char_if.ready) begin
        parse_date_char(char_if.char_code);
        if (char_if.line_end) begin
          calc = close_date_line();
          if (typed_pending) begin
            pending_days.push_back(typed_result);
            typed_pending = 1'b0;
          end else begin
            pending_days.push_back(calc);
          end
        end
      end
      if (day_if.valid && day_if.ready) begin
        if (pending_days.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = pending_days.pop_front();
          if (day_if.date_valid !== want.date_valid)
            report_mismatch($sformatf("date_valid got %b want %b",
                                      day_if.date_valid, want.date_valid));
          if (day_if.day_number !== want.day_number)
            report_mismatch($sformatf("day_number got %0d want %0d",
                                      day_if.day_number, want.day_number));
        end
      end
    end
  end

  // watchdog on cycles with no beat and no register access
  always @(posedge clk) begin
    int quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      if ((char_if.valid && char_if.ready) || (day_if.valid && day_if.ready) ||
          (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side ready, with random stalls and a long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    day_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        day_if.ready <= 1'b0;
        hold_left--;
      end else begin
        day_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // one char beat; entered and left at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      char_if.valid <= 1'b0;
      @(negedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    char_if.line_end  <= last;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  // stop offering and let every expected result come out
  task automatic drain_results();
    char_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_days.size() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CHAR_W-1:0] data,
                            output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_DAY_DELIM, 2'b00};
    pwdata  <= PDATA_W'(data);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (wr) model_delim = data;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // delimiter write while idle, then read back
  task automatic set_delimiter(input logic [CHAR_W-1:0] delim);
    logic [PDATA_W-1:0] rd;
    drain_results();
    repeat (4) @(negedge clk);
    apb_access(1'b1, delim, rd);
    @(negedge clk);
    apb_access(1'b0, delim, rd);
    if (rd[CHAR_W-1:0] !== delim)
      report_mismatch($sformatf("delimiter read %0d want %0d", rd[CHAR_W-1:0], delim));
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // one field: spaces, optional plus, leading zeros, digits, spaces
  function automatic void put_field(input int unsigned val);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
    if ($urandom_range(3) == 0) line_buf.push_back(CH_PLUS);
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
    put_text($sformatf("%0d", val));
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
  endfunction

  // random line: mostly well-formed dates, some broken, some noise
  function automatic void build_line();
    int unsigned kind;
    int unsigned r;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned dim;
    int unsigned pos;
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 10))
        line_buf.push_back(($urandom_range(1) == 0) ? CHAR_W'($urandom_range(255))
                                                    : CHAR_W'($urandom_range(8'h2B, 8'h39)));
      return;
    end
    r = $urandom_range(99);
    if (r < 70) yr = $urandom_range(1, 2100);
    else if (r < 80) yr = $urandom_range(1, MAX_YEAR);
    else if (r < 88) yr = $urandom_range(MAX_YEAR - 3, MAX_YEAR + 3);
    else if (r < 92) yr = 0;
    else yr = $urandom_range(0, 9999999);
    mo = ($urandom_range(99) < 88) ? $urandom_range(1, 12) : $urandom_range(0, 400);
    if (mo >= 1 && mo <= 12 && $urandom_range(99) < 82) begin
      dim = month_days[mo-1] + ((mo == 2 && yr % 4 == 0) ? 1 : 0);
      dy  = $urandom_range(1, dim);
    end else begin
      dy = $urandom_range(0, 400);
    end
    put_field(yr);
    line_buf.push_back(CH_MINUS);
    put_field(mo);
    line_buf.push_back(CH_MINUS);
    put_field(dy);
    if ($urandom_range(1) == 1) begin
      line_buf.push_back(model_delim);
      repeat ($urandom_range(0, 4)) line_buf.push_back(CHAR_W'($urandom_range(255)));
    end
    // broken: one char replaced or the line cut short
    if (kind < 25) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      if ($urandom_range(1) == 1) line_buf[pos] = CHAR_W'($urandom_range(255));
      else while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
    end
  endfunction

  // main sequence
  initial begin
    int  sent;
    bit  held;
    bit  paused;
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    char_if.line_end  = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_req          = 1'b0;
    typed_pending     = 1'b0;
    err_count         = 0;
    src_idle_pct      = 29;
    snk_idle_pct      = 54;
    model_delim       = DELIM_RESET;
    clear_date_line();
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed lines
    foreach (date_rows[i]) begin
      if (date_rows[i].delim != model_delim) set_delimiter(date_rows[i].delim);
      line_buf.delete();
      put_text(date_rows[i].text);
      if (date_rows[i].typed) begin
        typed_result  = date_rows[i].result;
        typed_pending = 1'b1;
      end
      send_line();
    end

    // random phases, one delimiter each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) begin
        src_idle_pct = 29;
        snk_idle_pct = 54;
      end else if (ph < 6) begin
        src_idle_pct = 54;
        snk_idle_pct = 29;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_delimiter(phase_delims[ph]);
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (sent < PHASE_CHARS) begin
        // long result-side hold while chars keep coming
        if (ph == 1 && !held && sent >= PHASE_CHARS / 2) begin
          char_if.valid <= 1'b0;
          @(posedge clk);
          hold_req = 1'b1;
          @(negedge clk);
          held = 1'b1;
        end
        // sender pause until the pipe is empty
        if (ph == 4 && !paused && sent >= PHASE_CHARS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        build_line();
        send_line();
        sent += line_buf.size();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
